FILE: sv/assert_macros.svh
// Assertion macros shared by the recommender modules.
// Needs signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CNR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cnr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CNR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cnr: next-cycle check failed");

`endif

FILE: sv/cnr_pkg.sv
// Shared types and constants for the common-neighbor recommender.
// No dependencies.
package cnr_pkg;

  localparam int NODE_W        = 6;
  localparam int COUNT_W       = 7;
  localparam int MAX_NODES_DEF = 64;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 16;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_REC = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RSEL_A,
    RSEL_B,
    RSEL_CAND
  } rd_sel_t;

  typedef enum logic {
    WSEL_A,
    WSEL_B
  } wr_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    clr_scan;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    load_user;
    logic    cand_inc;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ab_in_range;
    logic a_in_range;
    logic scan_done;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/cnr_dp.sv
// Datapath: adjacency memory with row valid bits, candidate scan pipeline,
// best-candidate tracking and the result register. Depends on cnr_pkg.
`include "assert_macros.svh"

module cnr_dp #(
  parameter int MAX_NODES = cnr_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [cnr_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic                         in_op,
  input  logic [cnr_pkg::NODE_W-1:0]   in_a,
  input  logic [cnr_pkg::NODE_W-1:0]   in_b,
  input  cnr_pkg::cmd_t                cmd,
  output cnr_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cnr_pkg::NODE_W-1:0]   out_recommended,
  output logic                         out_found,
  output logic [cnr_pkg::COUNT_W-1:0]  out_common
);
  import cnr_pkg::*;

  localparam int ROWS = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
  localparam int AW   = $clog2(ROWS);
  localparam int CW   = $clog2(ROWS + 1);
  localparam logic [COUNT_W-1:0] ROWS_C = COUNT_W'(ROWS);

  logic [COUNT_W-1:0] node_count;
  op_t                op_r;
  logic [NODE_W-1:0]  a_r;
  logic [NODE_W-1:0]  b_r;

  logic [ROWS-1:0]    mem [ROWS];
  logic [ROWS-1:0]    row_valid;
  logic [ROWS-1:0]    rd_row;
  logic               rd_vld;
  logic [ROWS-1:0]    rd_eff;
  logic [ROWS-1:0]    user_row;

  logic [CW-1:0]      cand;
  logic [COUNT_W-1:0] limit;

  logic               p1_valid;
  logic [AW-1:0]      p1_idx;
  logic               p2_valid;
  logic [AW-1:0]      p2_idx;
  logic               p2_elig;
  logic [CW-1:0]      p2_score;

  logic               found;
  logic [AW-1:0]      best;
  logic [CW-1:0]      best_score;

  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      wr_bit;
  logic [ROWS-1:0]    wr_row;
  logic [ROWS-1:0]    and_row;
  logic [CW-1:0]      score;
  logic               elig;

  assign limit = (node_count > ROWS_C) ? ROWS_C : node_count;

  // rows never written read as zero
  assign rd_eff = rd_vld ? rd_row : '0;

  always_comb begin
    case (cmd.rd_sel)
      RSEL_A:    rd_addr = a_r[AW-1:0];
      RSEL_B:    rd_addr = b_r[AW-1:0];
      RSEL_CAND: rd_addr = cand[AW-1:0];
      default:   rd_addr = a_r[AW-1:0];
    endcase
  end

  always_comb begin
    if (cmd.wr_sel == WSEL_A) begin
      wr_addr = a_r[AW-1:0];
      wr_bit  = b_r[AW-1:0];
    end else begin
      wr_addr = b_r[AW-1:0];
      wr_bit  = a_r[AW-1:0];
    end
    wr_row         = rd_eff;
    wr_row[wr_bit] = 1'b1;
  end

  assign and_row = user_row & rd_eff;

  always_comb begin
    score = '0;
    for (int k = 0; k < ROWS; k++) begin
      score = score + CW'(and_row[k]);
    end
  end

  assign elig = (p1_idx != a_r[AW-1:0]) && !user_row[p1_idx];

  // adjacency rows, one port each way, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= op_t'(in_op);
      a_r  <= in_a;
      b_r  <= in_b;
    end
    if (cmd.load_user) begin
      user_row <= rd_eff;
    end
    p1_idx   <= cand[AW-1:0];
    p2_idx   <= p1_idx;
    p2_elig  <= elig;
    p2_score <= score;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      cand       <= '0;
      p1_valid   <= 1'b0;
      p2_valid   <= 1'b0;
      found      <= 1'b0;
      best       <= '0;
      best_score <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      p1_valid <= cmd.rd_en && (cmd.rd_sel == RSEL_CAND);
      p2_valid <= p1_valid;
      if (cmd.clr_scan) begin
        cand       <= '0;
        found      <= 1'b0;
        best       <= '0;
        best_score <= '0;
      end else begin
        if (cmd.cand_inc) begin
          cand <= cand + 1'b1;
        end
        // strict compare keeps the lowest index on ties
        if (p2_valid && p2_elig && (!found || p2_score > best_score)) begin
          found      <= 1'b1;
          best       <= p2_idx;
          best_score <= p2_score;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_recommended <= NODE_W'(best);
      out_found       <= found;
      out_common      <= COUNT_W'(best_score);
    end
  end

  always_comb begin
    sts.op          = op_r;
    sts.a_in_range  = COUNT_W'(a_r) < ROWS_C;
    sts.ab_in_range = (COUNT_W'(a_r) < ROWS_C) && (COUNT_W'(b_r) < ROWS_C);
    sts.scan_done   = COUNT_W'(cand) == limit;
    sts.pipe_busy   = p1_valid || p2_valid;
    sts.out_free    = !out_valid || out_ready;
  end

  `CNR_ASSERT_NXT(a_pipe_follow, p1_valid, p2_valid)
  `CNR_ASSERT_IMP(a_found_score, !found, best_score == '0)
  `CNR_ASSERT_NXT(a_scan_no_write, cmd.rd_en && cmd.rd_sel == RSEL_CAND, !cmd.wr_en)

endmodule

FILE: sv/cnr_ctrl.sv
// Controller state machine: sequences add and recommend operations
// through the datapath. Depends on cnr_pkg.
`include "assert_macros.svh"

module cnr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output cnr_pkg::cmd_t cmd,
  input  cnr_pkg::sts_t sts
);
  import cnr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_RA,
    S_ADD_WA,
    S_ADD_WB,
    S_REC_RU,
    S_REC_LU,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.op == OP_ADD) begin
          state_next = sts.ab_in_range ? S_ADD_RA : S_IDLE;
        end else begin
          state_next = sts.a_in_range ? S_REC_RU : S_FINISH;
        end
      end
      S_ADD_RA: state_next = S_ADD_WA;
      S_ADD_WA: state_next = S_ADD_WB;
      S_ADD_WB: state_next = S_IDLE;
      S_REC_RU: state_next = S_REC_LU;
      S_REC_LU: state_next = S_SCAN;
      S_SCAN: begin
        if (sts.scan_done && !sts.pipe_busy) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RSEL_A;
    cmd.wr_sel    = WSEL_A;
    cmd.load_in   = in_valid && in_ready;
    case (state)
      S_DECODE: cmd.clr_scan = 1'b1;
      S_ADD_RA: cmd.rd_en = 1'b1;
      S_ADD_WA: begin
        // write row a while fetching row b
        cmd.wr_en  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RSEL_B;
      end
      S_ADD_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_B;
      end
      S_REC_RU: cmd.rd_en = 1'b1;
      S_REC_LU: cmd.load_user = 1'b1;
      S_SCAN: begin
        if (!sts.scan_done) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RSEL_CAND;
          cmd.cand_inc = 1'b1;
        end
      end
      S_FINISH: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  `CNR_ASSERT_IMP(a_out_free, cmd.out_load, sts.out_free)
  `CNR_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state == S_DECODE)
  `CNR_ASSERT_IMP(a_idle_quiet, in_ready, !sts.pipe_busy)

endmodule

FILE: sv/common_neighbor_recommender_core.sv
// Top level of the common-neighbor friend recommender.
// Joins cnr_ctrl and cnr_dp; depends on cnr_pkg.
//
//   channel   dir   beat fields
//   s_axis    in    tuser: operation; tdata: node_a, node_b
//   m_axis    out   tuser: found; tdata: recommended, common_count
//   cfg       in    cfg_wr_data: node_count (write only)
//
// Add: accept, decode, read a, write a, write b; no new beat is taken before it ends.
// Recommend: accept, decode, user row read and load, one candidate row per cycle
//   through the single read port for min(node_count, rows) candidates, scan drain,
//   finish. A zero node_count scans nothing; a user beyond storage skips to finish.
// Reset marks all rows empty at once through per-row valid bits.
// Input is taken only when idle; a result still held in the output register
//   stalls the next recommend in its finish state until the master side takes it.
module common_neighbor_recommender_core #(
  parameter int MAX_NODES = cnr_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [cnr_pkg::COUNT_W-1:0]     cfg_wr_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cnr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // node_a, node_b, zero pad
  input  logic                            s_axis_tuser,  // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cnr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // recommended, common_count, pad
  output logic                            m_axis_tuser   // found
);
  import cnr_pkg::*;

  localparam int OUT_PAD = OUT_TDATA_W - NODE_W - COUNT_W;

  cmd_t               cmd;
  sts_t               sts;
  logic [NODE_W-1:0]  recommended;
  logic [COUNT_W-1:0] common_count;

  cnr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  cnr_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_op           (s_axis_tuser),
    .in_a            (s_axis_tdata[NODE_W-1:0]),
    .in_b            (s_axis_tdata[2*NODE_W-1:NODE_W]),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_recommended (recommended),
    .out_found       (m_axis_tuser),
    .out_common      (common_count)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, common_count, recommended};

endmodule

FILE: sim/common_neighbor_recommender_core_tb.sv
// Self-checking testbench for common_neighbor_recommender_core: random and directed
// add / recommend beats, checked against an in-bench adjacency matrix predictor.
// Depends on cnr_pkg and the recommender RTL only.
module common_neighbor_recommender_core_tb;
  import cnr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 80;

  typedef struct packed {
    logic [NODE_W-1:0]  rec;
    logic               found;
    logic [COUNT_W-1:0] cnt;
  } rec_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]     cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // predictor state
  logic [63:0]        adj_rows [64];
  logic [COUNT_W-1:0] node_cnt;
  rec_t               rec_q [$];

  int   send_idle = 0;
  int   recv_idle = 0;
  int   errors    = 0;
  int   cycles    = 0;
  rec_t want_rec;
  rec_t got_rec;

  common_neighbor_recommender_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, rec_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker: every beat on the master side against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_rec.rec   = m_axis_tdata[NODE_W-1:0];
      got_rec.cnt   = m_axis_tdata[NODE_W+COUNT_W-1:NODE_W];
      got_rec.found = m_axis_tuser;
      if (rec_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual rec=%0d found=%0d cnt=%0d",
                 $time, got_rec.rec, got_rec.found, got_rec.cnt);
        errors++;
      end else begin
        want_rec = rec_q.pop_front();
        if (got_rec.rec !== want_rec.rec) begin
          $display("%0t: recommended mismatch, expected %0d actual %0d",
                   $time, want_rec.rec, got_rec.rec);
          errors++;
        end
        if (got_rec.found !== want_rec.found) begin
          $display("%0t: found mismatch, expected %0d actual %0d",
                   $time, want_rec.found, got_rec.found);
          errors++;
        end
        if (got_rec.cnt !== want_rec.cnt) begin
          $display("%0t: common_count mismatch, expected %0d actual %0d",
                   $time, want_rec.cnt, got_rec.cnt);
          errors++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:NODE_W+COUNT_W] !== '0) begin
          $display("%0t: tdata pad mismatch, expected 0 actual %h",
                   $time, m_axis_tdata[OUT_TDATA_W-1:NODE_W+COUNT_W]);
          errors++;
        end
      end
    end
  end

  function automatic rec_t predict_recommendation(input logic [NODE_W-1:0] user);
    rec_t        r;
    int          lim;
    int          score;
    logic [63:0] row;
    r   = '0;
    lim = (node_cnt > 64) ? 64 : int'(node_cnt);
    row = adj_rows[user];
    for (int i = 0; i < lim; i++) begin
      if (i != int'(user) && !row[i]) begin
        score = $countones(row & adj_rows[i]);
        if (!r.found || score > int'(r.cnt)) begin
          r.found = 1'b1;
          r.rec   = i[NODE_W-1:0];
          r.cnt   = score[COUNT_W-1:0];
        end
      end
    end
    return r;
  endfunction

  task automatic send_op(input op_t op, input logic [NODE_W-1:0] a,
                         input logic [NODE_W-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W-2*NODE_W){1'b0}}, b, a};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_ADD) begin
      adj_rows[a][b] = 1'b1;
      adj_rows[b][a] = 1'b1;
    end else begin
      rec_q.insert(rec_q.size(), predict_recommendation(a));
    end
  endtask

  // hold off the sender until every predicted result is out, plus scan time
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (rec_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_node_count(input logic [COUNT_W-1:0] val);
    wait_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    node_cnt = val;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_empty_graph();
    send_op(OP_REC, 6'd0, 6'd0);
    send_op(OP_REC, 6'd63, 6'd63);
    send_op(OP_REC, 6'd31, 6'd0);
  endtask

  task automatic test_edges_and_self();
    send_op(OP_ADD, 6'd0, 6'd63);
    send_op(OP_ADD, 6'd63, 6'd0);   // duplicate edge
    send_op(OP_ADD, 6'd5, 6'd5);    // self friendship
    send_op(OP_ADD, 6'd0, 6'd1);
    send_op(OP_ADD, 6'd1, 6'd5);
    send_op(OP_ADD, 6'd0, 6'd5);
    send_op(OP_REC, 6'd0, 6'd0);
    send_op(OP_REC, 6'd63, 6'd42);
    send_op(OP_REC, 6'd5, 6'd0);
    send_op(OP_REC, 6'd1, 6'd63);
  endtask

  task automatic test_node_count_limits();
    set_node_count(7'd0);
    send_op(OP_REC, 6'd0, 6'd0);    // nothing scanned
    set_node_count(7'd1);
    send_op(OP_REC, 6'd0, 6'd0);    // only candidate is the user
    send_op(OP_REC, 6'd40, 6'd0);   // asker above node_count
    set_node_count(7'd2);
    send_op(OP_REC, 6'd0, 6'd0);    // only candidate is already a friend
    send_op(OP_ADD, 6'd62, 6'd2);   // stored although above node_count
    set_node_count(7'd127);         // saturates to 64
    send_op(OP_REC, 6'd63, 6'd0);
    send_op(OP_REC, 6'd2, 6'd0);
    set_node_count(7'd64);
    send_op(OP_REC, 6'd62, 6'd0);
  endtask

  task automatic test_random(input int n_items);
    int                sent;
    int                lo;
    int                span;
    int                adds;
    logic              paused;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        // a few edges inside a window of users, then a query from that window
        lo   = $urandom_range(63);
        span = $urandom_range(1, 12);
        adds = $urandom_range(1, 4);
        for (int k = 0; k < adds; k++) begin
          a = 6'((lo + $urandom_range(span)) % 64);
          b = 6'((lo + $urandom_range(span)) % 64);
          send_op(OP_ADD, a, b);
        end
        send_op(OP_REC, 6'((lo + $urandom_range(span)) % 64), 6'($urandom));
        sent += adds + 1;
      end else begin
        send_op($urandom_range(1) ? OP_REC : OP_ADD, 6'($urandom), 6'($urandom));
        sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        wait_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) adj_rows[i] = '0;
    node_cnt = NODE_COUNT_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 29;
    recv_idle = 60;
    test_empty_graph();
    test_edges_and_self();
    test_node_count_limits();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 29 : (mode == 1) ? 60 : 0;
      recv_idle = (mode == 0) ? 60 : (mode == 1) ? 29 : 0;
      case (mode)
        0: begin
          set_node_count(7'd64);
          test_random(325);
          set_node_count(7'($urandom_range(2, 63)));
          test_random(325);
        end
        1: begin
          set_node_count(7'($urandom_range(65, 127)));
          test_random(325);
          set_node_count(7'($urandom_range(3, 8)));
          test_random(325);
        end
        default: begin
          set_node_count(7'($urandom_range(1, 16)));
          test_random(325);
          set_node_count(7'd64);
          test_random(325);
        end
      endcase
    end

    wait_results();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/cnr_pkg.sv
sv/cnr_dp.sv
sv/cnr_ctrl.sv
sv/common_neighbor_recommender_core.sv
sim/common_neighbor_recommender_core_tb.sv
